FILE: sv/signed_divide_by_invariant_core_macros.svh
// ----------------------------------------------------------------------------
// signed divide by invariant: assertion macros
// shared property shorthand for the port checker, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef SIGNED_DIVIDE_BY_INVARIANT_CORE_MACROS_SVH
`define SIGNED_DIVIDE_BY_INVARIANT_CORE_MACROS_SVH

// consequent checked in the same cycle
`define SDI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the following cycle
`define SDI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// widths, path codes and the derived divisor setup shared by the divider
// ----------------------------------------------------------------------------
package sdi_pkg;

	localparam int W  = 32;
	localparam int LW = $clog2(W);

	typedef logic [2:0] path_t;

	localparam path_t PATH_ZERO  = 3'd0;
	localparam path_t PATH_ONE   = 3'd1;
	localparam path_t PATH_POW2  = 3'd2;
	localparam path_t PATH_SMALL = 3'd3;
	localparam path_t PATH_LARGE = 3'd4;

	typedef struct packed {
		path_t               path;
		logic                neg;
		logic [LW-1:0]       shift;
		logic [W-1:0]        bias;
		logic signed [W+1:0] mult;
	} cfg_t;

endpackage

FILE: sv/signed_divide_by_invariant_core.sv
// dividend_s1 then quotient_q/done registers; one dividend per cycle while busy is low
// busy is high only during setup after a nonzero divisor write; start is taken when low
// a power-of-two divisor write sets busy for the log search only, other nonzero
// ones for the log search, two long divisions and the shift reductions
// reset: divisor reads as 1, pipeline empty, busy and done low
// ----------------------------------------------------------------------------
// signed_divide_by_invariant_core
// signed divide by a register-held divisor: multiply-high or biased shift, truncating
// ----------------------------------------------------------------------------
module signed_divide_by_invariant_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [sdi_pkg::W-1:0] dividend,
	input  logic                         wr_en,
	input  logic signed [sdi_pkg::W-1:0] wr_data,
	output logic                         done,
	output logic signed [sdi_pkg::W-1:0] quotient,
	output logic                         zero_divisor
);
	import sdi_pkg::*;

	cfg_t                  cfg;
	logic                  setup_busy;
	logic                  accept;

	logic                  valid_s1;
	logic signed [W-1:0]   dividend_s1;

	logic                  done_q;
	logic [W-1:0]          quotient_q;
	logic                  zero_q;

	logic signed [W+1:0]   mult;
	logic signed [2*W+1:0] prod;
	logic signed [W+2:0]   base;
	logic signed [W+2:0]   addend;
	logic signed [W+2:0]   sum;
	logic signed [W+2:0]   shifted;
	logic                  fix;
	logic [W-1:0]          t;
	logic [W-1:0]          res;

	sdi_setup u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.busy    (setup_busy),
		.cfg     (cfg)
	);

	assign busy   = setup_busy;
	assign accept = start && !setup_busy;

	assign mult = cfg.mult;
	assign prod = mult * dividend_s1;

	always_comb begin
		base   = (W+3)'(dividend_s1);
		addend = '0;
		fix    = 1'b0;
		case (cfg.path)
			PATH_SMALL: begin
				base = (W+3)'($signed(prod[2*W+1:W]));
				fix  = dividend_s1[W-1];
			end
			PATH_LARGE: begin
				base   = (W+3)'($signed(prod[2*W+1:W]));
				addend = (W+3)'(dividend_s1);
				fix    = dividend_s1[W-1];
			end
			PATH_POW2: begin
				if (dividend_s1[W-1]) begin
					addend = (W+3)'({1'b0, cfg.bias});
				end
			end
			default: begin
			end
		endcase
		sum     = base + addend;
		shifted = sum >>> cfg.shift;
		t       = shifted[W-1:0];
		res     = cfg.neg ? (~t + W'(!fix)) : (t + W'(fix));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dividend_s1 <= dividend;
		end
		if (valid_s1) begin
			quotient_q <= (cfg.path == PATH_ZERO) ? '0 : res;
			zero_q     <= cfg.path == PATH_ZERO;
		end
	end

	assign done         = done_q;
	assign quotient     = quotient_q;
	assign zero_divisor = zero_q;

endmodule

FILE: sv/sdi_setup.sv
// ----------------------------------------------------------------------------
// sdi_setup
// divisor register and sequencer deriving ceil log2, magic multiplier and shift
// ----------------------------------------------------------------------------
module sdi_setup (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [sdi_pkg::W-1:0] wr_data,
	output logic                  busy,
	output sdi_pkg::cfg_t         cfg
);
	import sdi_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOG  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_RED  = 2'd3;

	localparam logic [LW:0]  CNT_LAST = (LW+1)'(2*W-1);
	localparam logic [LW:0]  CNT_W    = (LW+1)'(W);
	localparam logic [W+1:0] TWO_W    = (W+2)'(1) << W;

	logic [1:0]    state_q;
	cfg_t          cfg_q;
	logic [W-1:0]  mag_q;
	logic [W-1:0]  pw_q;
	logic [LW-1:0] l_q;
	logic [LW:0]   cnt_q;
	logic [W-1:0]  rlo_q;
	logic [W-1:0]  rhi_q;
	logic [W:0]    qlo_q;
	logic [W:0]    qhi_q;

	logic [W-1:0]  wr_mag;
	logic          bit_lo;
	logic          bit_hi;
	logic [W:0]    trial_lo;
	logic [W:0]    trial_hi;
	logic          ge_lo;
	logic          ge_hi;
	logic [W-1:0]  rem_lo_nx;
	logic [W-1:0]  rem_hi_nx;
	logic          shrink;

	assign wr_mag    = wr_data[W-1] ? (~wr_data + 1'b1) : wr_data;
	assign bit_lo    = cnt_q == (CNT_W + {1'b0, l_q});
	assign bit_hi    = bit_lo || (cnt_q == ({1'b0, l_q} + (LW+1)'(1)));
	assign trial_lo  = {rlo_q, bit_lo};
	assign trial_hi  = {rhi_q, bit_hi};
	assign ge_lo     = trial_lo >= {1'b0, mag_q};
	assign ge_hi     = trial_hi >= {1'b0, mag_q};
	assign rem_lo_nx = ge_lo ? W'(trial_lo - {1'b0, mag_q}) : trial_lo[W-1:0];
	assign rem_hi_nx = ge_hi ? W'(trial_hi - {1'b0, mag_q}) : trial_hi[W-1:0];
	assign shrink    = (qlo_q[W:1] < qhi_q[W:1]) && (l_q != '0);

	assign busy = state_q != ST_IDLE;
	assign cfg  = cfg_q;

	// sequencer and derived setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cfg_q.path <= PATH_ONE;
			cfg_q.neg  <= 1'b0;
			cfg_q.shift <= '0;
			cfg_q.bias <= '0;
			cfg_q.mult <= '0;
		end else if (wr_en) begin
			cfg_q.neg <= wr_data[W-1];
			if (wr_data == '0) begin
				cfg_q.path  <= PATH_ZERO;
				cfg_q.shift <= '0;
				cfg_q.bias  <= '0;
				cfg_q.mult  <= '0;
				state_q     <= ST_IDLE;
			end else begin
				state_q <= ST_LOG;
			end
		end else begin
			case (state_q)
				ST_LOG: begin
					if (pw_q >= mag_q) begin
						if (pw_q == mag_q) begin
							cfg_q.path  <= (l_q == '0) ? PATH_ONE : PATH_POW2;
							cfg_q.shift <= l_q;
							cfg_q.bias  <= pw_q - 1'b1;
							cfg_q.mult  <= '0;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_RED;
					end
				end
				ST_RED: begin
					if (!shrink) begin
						cfg_q.shift <= l_q;
						cfg_q.bias  <= '0;
						if (qhi_q[W:W-1] == 2'b00) begin
							cfg_q.path <= PATH_SMALL;
							cfg_q.mult <= (W+2)'(qhi_q);
						end else begin
							cfg_q.path <= PATH_LARGE;
							cfg_q.mult <= (W+2)'(qhi_q) - TWO_W;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// log search, two long divisions, shift reduction
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mag_q <= wr_mag;
			pw_q  <= W'(1);
			l_q   <= '0;
		end else begin
			case (state_q)
				ST_LOG: begin
					if (pw_q < mag_q) begin
						pw_q <= pw_q << 1;
						l_q  <= l_q + 1'b1;
					end else begin
						cnt_q <= CNT_LAST;
						rlo_q <= '0;
						rhi_q <= '0;
						qlo_q <= '0;
						qhi_q <= '0;
					end
				end
				ST_DIV: begin
					rlo_q <= rem_lo_nx;
					rhi_q <= rem_hi_nx;
					qlo_q <= {qlo_q[W-1:0], ge_lo};
					qhi_q <= {qhi_q[W-1:0], ge_hi};
					cnt_q <= cnt_q - 1'b1;
				end
				ST_RED: begin
					if (shrink) begin
						qlo_q <= qlo_q >> 1;
						qhi_q <= qhi_q >> 1;
						l_q   <= l_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: sv/sdi_checker.sv
// ----------------------------------------------------------------------------
// sdi_checker
// port-level checks on result timing, zero divisor and setup busy
// ----------------------------------------------------------------------------
`include "signed_divide_by_invariant_core_macros.svh"

module sdi_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [sdi_pkg::W-1:0] dividend,
	input logic                         wr_en,
	input logic signed [sdi_pkg::W-1:0] wr_data,
	input logic                         done,
	input logic signed [sdi_pkg::W-1:0] quotient,
	input logic                         zero_divisor
);
	import sdi_pkg::*;

	// every accepted beat comes back as a done beat
	`SDI_ASSERT_NEXT(a_beat_returns, start && !busy, ##1 done, "accepted beat gave no result")
	// no result beat without an accepted beat
	`SDI_ASSERT_NOW(a_no_extra_beat, done, $past(start && !busy, 2), "result beat without input")
	// zero divisor forces a zero quotient
	`SDI_ASSERT_NOW(a_zero_quot, done && zero_divisor, quotient == '0, "zero divisor quotient")
	// nonzero divisor write starts setup
	`SDI_ASSERT_NEXT(a_setup_busy, wr_en && (wr_data != '0), busy, "no setup after divisor write")

endmodule

bind signed_divide_by_invariant_core sdi_checker u_sdi_checker (.*);
